// ===== rtl/bfd_pkg.sv =====
// box filter downsampler: shared types, register codes and constants
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package bfd_pkg;

  localparam int CH_W       = 8;
  localparam int SCALE_W    = 4;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int SCALE_RST  = 4;
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;

  localparam int QUEUE_DEPTH = 4;

  // reciprocal of scale squared, scaled by 2**RECIP_SHIFT and rounded up
  localparam int RECIP_W     = 25;
  localparam int RECIP_SHIFT = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic first;
    logic last;
    logic fend;
  } tag_t;

  function automatic logic [RECIP_W-1:0] recip(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] m;
    case (s)
      4'd2:    m = 25'd4194304;
      4'd3:    m = 25'd1864136;
      4'd4:    m = 25'd1048576;
      4'd5:    m = 25'd671089;
      4'd6:    m = 25'd466034;
      4'd7:    m = 25'd342393;
      4'd8:    m = 25'd262144;
      4'd9:    m = 25'd207127;
      4'd10:   m = 25'd167773;
      4'd11:   m = 25'd138655;
      4'd12:   m = 25'd116509;
      4'd13:   m = 25'd99274;
      4'd14:   m = 25'd85599;
      4'd15:   m = 25'd74566;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bfd_if.sv =====
// box filter downsampler: pixel and average channel interfaces
// depends on bfd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bfd_pix_if;
  logic                    valid;
  logic                    ready;
  logic [bfd_pkg::CH_W-1:0] red_in;
  logic [bfd_pkg::CH_W-1:0] green_in;
  logic [bfd_pkg::CH_W-1:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface bfd_avg_if;
  logic                    valid;
  logic                    ready;
  logic [bfd_pkg::CH_W-1:0] red_avg;
  logic [bfd_pkg::CH_W-1:0] green_avg;
  logic [bfd_pkg::CH_W-1:0] blue_avg;
  logic                    frame_end;

  modport source (output valid, output red_avg, output green_avg, output blue_avg,
                  output frame_end, input ready);
  modport sink   (input valid, input red_avg, input green_avg, input blue_avg,
                  input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/box_filter_downsampler.sv =====
// box filter downsampler top level: front, request queue and back
// depends on bfd_pkg, bfd_if, bfd_front, bfd_fifo, bfd_back, bfd_ram
//
//   port    dir   handshake        payload
//   pix_i   in    valid / ready    red_in, green_in, blue_in
//   avg_o   out   valid / ready    red_avg, green_avg, blue_avg, frame_end
//   cfg     in    cfg_we_i         cfg_idx_i, cfg_data_i
//
// one pixel per cycle while the result side keeps up; after the last pixel of its block is
// accepted, its result passes the queue, accumulate and divide stages and the result register.
// throughput is set by the column-sum ram read-add-write loop, closed by a write bypass.
// no clearing pass after reset: every sum entry is overwritten by the first pixel of a block.
// a held result freezes the back; the queue of QUEUE_DEPTH requests then fills and ready drops.
`timescale 1ns / 1ps
`default_nettype none

module box_filter_downsampler #(
  parameter int MAX_OUT_WIDTH  = 1024,
  parameter int MAX_SCALE      = 8,
  parameter int MAX_OUT_HEIGHT = 4096
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bfd_pix_if.sink                             pix_i,
  bfd_avg_if.source                           avg_o
);

  localparam int COL_W   = $clog2(MAX_OUT_WIDTH);
  localparam int SUM_W   = $clog2(MAX_SCALE * MAX_SCALE * 255 + 1);
  localparam int PIX_W   = $bits(bfd_pkg::pix_t);
  localparam int TAG_W   = $bits(bfd_pkg::tag_t);
  localparam int ENTRY_W = PIX_W + COL_W + TAG_W;

  logic                          push, full, pop, empty;
  bfd_pkg::pix_t                 push_pix, head_pix;
  logic [COL_W-1:0]              push_col, head_col;
  bfd_pkg::tag_t                 push_tag, head_tag;
  logic [ENTRY_W-1:0]            head_entry;
  logic [bfd_pkg::SCALE_W-1:0]   scale;

  bfd_front #(
    .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
    .MAX_SCALE      (MAX_SCALE),
    .MAX_OUT_HEIGHT (MAX_OUT_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_i),
    .full_i     (full),
    .push_o     (push),
    .push_pix_o (push_pix),
    .push_col_o (push_col),
    .push_tag_o (push_tag),
    .scale_o    (scale)
  );

  bfd_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (bfd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_pix, push_col, push_tag}),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_entry),
    .empty_o     (empty)
  );

  assign {head_pix, head_col, head_tag} = head_entry;

  bfd_back #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .SUM_W         (SUM_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_pix_i (head_pix),
    .head_col_i (head_col),
    .head_tag_i (head_tag),
    .pop_o      (pop),
    .scale_i    (scale),
    .avg_o      (avg_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bfd_ram.sv =====
// box filter downsampler: generic single-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bfd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfd_fifo.sv =====
// box filter downsampler: small flop queue between front and back
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bfd_fifo #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] head_o,
  output logic                  empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfd_front.sv =====
// box filter downsampler: config registers, pixel intake and block position tracking
// depends on bfd_pkg and bfd_if
`timescale 1ns / 1ps
`default_nettype none

module bfd_front #(
  parameter int MAX_OUT_WIDTH  = 1024,
  parameter int MAX_SCALE      = 8,
  parameter int MAX_OUT_HEIGHT = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [bfd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  bfd_pix_if.sink                                pix_i,
  input  wire logic                              full_i,
  output logic                                   push_o,
  output bfd_pkg::pix_t                          push_pix_o,
  output logic [$clog2(MAX_OUT_WIDTH)-1:0]       push_col_o,
  output bfd_pkg::tag_t                          push_tag_o,
  output logic [bfd_pkg::SCALE_W-1:0]            scale_o
);

  localparam int SCALE_W  = bfd_pkg::SCALE_W;
  localparam int WIDTH_W  = bfd_pkg::WIDTH_W;
  localparam int HEIGHT_W = bfd_pkg::HEIGHT_W;
  localparam int SUB_W    = $clog2(MAX_SCALE);
  localparam int COL_W    = $clog2(MAX_OUT_WIDTH);
  localparam int ROW_W    = $clog2(MAX_OUT_HEIGHT);

  localparam int SCALE_RST_C  = (bfd_pkg::SCALE_RST > MAX_SCALE) ? MAX_SCALE
                                                                 : bfd_pkg::SCALE_RST;
  localparam int WIDTH_RST_C  = (bfd_pkg::WIDTH_RST > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH
                                                                     : bfd_pkg::WIDTH_RST;
  localparam int HEIGHT_RST_C = (bfd_pkg::HEIGHT_RST > MAX_OUT_HEIGHT) ? MAX_OUT_HEIGHT
                                                                       : bfd_pkg::HEIGHT_RST;

  logic [SCALE_W-1:0]  scale_q, scale_d;
  logic [WIDTH_W-1:0]  width_q, width_d;
  logic [HEIGHT_W-1:0] height_q, height_d;
  logic [SUB_W-1:0]    subc_q, subc_d, subr_q, subr_d;
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;

  logic [SCALE_W-1:0]  v_scale;
  logic [WIDTH_W-1:0]  v_width;
  logic [HEIGHT_W-1:0] v_height;
  logic                cfg_hit;
  logic                accept;
  logic                subc_last, subr_last, col_last, row_last;

  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && !full_i;
  assign scale_o     = scale_q;

  // clamp register writes into the legal range
  always_comb begin
    v_scale  = cfg_data_i[SCALE_W-1:0];
    v_width  = cfg_data_i[WIDTH_W-1:0];
    v_height = cfg_data_i[HEIGHT_W-1:0];
    scale_d  = scale_q;
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        bfd_pkg::CFG_SCALE: begin
          cfg_hit = 1'b1;
          if (v_scale == '0) begin
            scale_d = SCALE_W'(1);
          end else if (int'(v_scale) > MAX_SCALE) begin
            scale_d = SCALE_W'(MAX_SCALE);
          end else begin
            scale_d = v_scale;
          end
        end
        bfd_pkg::CFG_WIDTH: begin
          cfg_hit = 1'b1;
          if (v_width == '0) begin
            width_d = WIDTH_W'(1);
          end else if (int'(v_width) > MAX_OUT_WIDTH) begin
            width_d = WIDTH_W'(MAX_OUT_WIDTH);
          end else begin
            width_d = v_width;
          end
        end
        bfd_pkg::CFG_HEIGHT: begin
          cfg_hit = 1'b1;
          if (v_height == '0) begin
            height_d = HEIGHT_W'(1);
          end else if (int'(v_height) > MAX_OUT_HEIGHT) begin
            height_d = HEIGHT_W'(MAX_OUT_HEIGHT);
          end else begin
            height_d = v_height;
          end
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // position within the frame
  always_comb begin
    subc_last = (SCALE_W'(subc_q) == scale_q - SCALE_W'(1));
    subr_last = (SCALE_W'(subr_q) == scale_q - SCALE_W'(1));
    col_last  = (WIDTH_W'(col_q) == width_q - WIDTH_W'(1));
    row_last  = (HEIGHT_W'(row_q) == height_q - HEIGHT_W'(1));
    subc_d = subc_q;
    subr_d = subr_q;
    col_d  = col_q;
    row_d  = row_q;
    if (!subc_last) begin
      subc_d = subc_q + SUB_W'(1);
    end else begin
      subc_d = '0;
      if (!col_last) begin
        col_d = col_q + COL_W'(1);
      end else begin
        col_d = '0;
        if (!subr_last) begin
          subr_d = subr_q + SUB_W'(1);
        end else begin
          subr_d = '0;
          row_d  = row_last ? '0 : row_q + ROW_W'(1);
        end
      end
    end
  end

  always_comb begin
    push_o           = accept;
    push_pix_o.red   = pix_i.red_in;
    push_pix_o.green = pix_i.green_in;
    push_pix_o.blue  = pix_i.blue_in;
    push_col_o       = col_q;
    push_tag_o.first = (subc_q == '0) && (subr_q == '0);
    push_tag_o.last  = subc_last && subr_last;
    push_tag_o.fend  = col_last && row_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_W'(SCALE_RST_C);
      width_q  <= WIDTH_W'(WIDTH_RST_C);
      height_q <= HEIGHT_W'(HEIGHT_RST_C);
      subc_q   <= '0;
      subr_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      scale_q  <= scale_d;
      width_q  <= width_d;
      height_q <= height_d;
      if (cfg_hit) begin
        subc_q <= '0;
        subr_q <= '0;
        col_q  <= '0;
        row_q  <= '0;
      end else if (accept) begin
        subc_q <= subc_d;
        subr_q <= subr_d;
        col_q  <= col_d;
        row_q  <= row_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bfd_back.sv =====
// box filter downsampler: column accumulation, mean by reciprocal multiply, result register
// depends on bfd_pkg, bfd_if and bfd_ram
`timescale 1ns / 1ps
`default_nettype none

module bfd_back #(
  parameter int MAX_OUT_WIDTH = 1024,
  parameter int SUM_W         = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              empty_i,
  input  wire bfd_pkg::pix_t                     head_pix_i,
  input  wire logic [$clog2(MAX_OUT_WIDTH)-1:0]  head_col_i,
  input  wire bfd_pkg::tag_t                     head_tag_i,
  output logic                                   pop_o,
  input  wire logic [bfd_pkg::SCALE_W-1:0]       scale_i,
  bfd_avg_if.source                              avg_o
);

  localparam int COL_W  = $clog2(MAX_OUT_WIDTH);
  localparam int CH_W   = bfd_pkg::CH_W;
  localparam int RW     = bfd_pkg::RECIP_W;
  localparam int PROD_W = SUM_W + RW;
  localparam int SH     = bfd_pkg::RECIP_SHIFT;

  logic                   adv;

  // accumulate stage
  logic                   b_valid_q;
  bfd_pkg::pix_t          b_pix_q;
  logic [COL_W-1:0]       b_col_q;
  bfd_pkg::tag_t          b_tag_q;
  logic [3*SUM_W-1:0]     rdata;
  logic [3*SUM_W-1:0]     old_sum;
  logic [3*SUM_W-1:0]     new_sum;

  // bypass of the write made in the previous advancing cycle
  logic                   fwd_valid_q;
  logic [COL_W-1:0]       fwd_col_q;
  logic [3*SUM_W-1:0]     fwd_sum_q;

  // divide stage
  logic                   c_valid_q;
  logic [3*SUM_W-1:0]     c_sum_q;
  logic                   c_fend_q;
  logic [RW-1:0]          recip_m;
  logic [PROD_W-1:0]      prod_r, prod_g, prod_b;

  // result register
  logic                   out_valid_q;
  logic [CH_W-1:0]        out_r_q, out_g_q, out_b_q;
  logic                   out_fend_q;

  assign adv   = !out_valid_q || avg_o.ready;
  assign pop_o = adv && !empty_i;

  bfd_ram #(
    .WIDTH (3 * SUM_W),
    .DEPTH (MAX_OUT_WIDTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (adv && b_valid_q),
    .waddr_i (b_col_q),
    .wdata_i (new_sum),
    .re_i    (pop_o),
    .raddr_i (head_col_i),
    .rdata_o (rdata)
  );

  always_comb begin
    old_sum = (fwd_valid_q && (fwd_col_q == b_col_q)) ? fwd_sum_q : rdata;
    if (b_tag_q.first) begin
      old_sum = '0;
    end
    new_sum[3*SUM_W-1:2*SUM_W] = old_sum[3*SUM_W-1:2*SUM_W] + SUM_W'(b_pix_q.red);
    new_sum[2*SUM_W-1:SUM_W]   = old_sum[2*SUM_W-1:SUM_W] + SUM_W'(b_pix_q.green);
    new_sum[SUM_W-1:0]         = old_sum[SUM_W-1:0] + SUM_W'(b_pix_q.blue);
  end

  // truncating mean: sum times rounded-up reciprocal of scale squared
  always_comb begin
    recip_m = bfd_pkg::recip(scale_i);
    prod_r  = PROD_W'(c_sum_q[3*SUM_W-1:2*SUM_W]) * PROD_W'(recip_m);
    prod_g  = PROD_W'(c_sum_q[2*SUM_W-1:SUM_W]) * PROD_W'(recip_m);
    prod_b  = PROD_W'(c_sum_q[SUM_W-1:0]) * PROD_W'(recip_m);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_pix_q <= head_pix_i;
      b_col_q <= head_col_i;
      b_tag_q <= head_tag_i;
    end
    if (adv) begin
      fwd_col_q <= b_col_q;
      fwd_sum_q <= new_sum;
      c_sum_q   <= new_sum;
      c_fend_q  <= b_tag_q.fend;
      out_r_q   <= prod_r[SH +: CH_W];
      out_g_q   <= prod_g[SH +: CH_W];
      out_b_q   <= prod_b[SH +: CH_W];
      out_fend_q <= c_fend_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      fwd_valid_q <= 1'b0;
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b_valid_q   <= !empty_i;
      fwd_valid_q <= b_valid_q;
      c_valid_q   <= b_valid_q && b_tag_q.last;
      out_valid_q <= c_valid_q;
    end
  end

  assign avg_o.valid     = out_valid_q;
  assign avg_o.red_avg   = out_r_q;
  assign avg_o.green_avg = out_g_q;
  assign avg_o.blue_avg  = out_b_q;
  assign avg_o.frame_end = out_fend_q;

endmodule

`default_nettype wire
